[sv/aies_pkg.sv]
package aies_pkg;

    localparam int REG_W      = 64;
    localparam int REG_DEPTH  = 32;
    localparam int REG_ADDR_W = $clog2(REG_DEPTH);

    // register file entry 31 holds the stack pointer
    localparam logic [REG_ADDR_W-1:0] SP_INDEX = REG_ADDR_W'(31);

    // instruction classes
    localparam logic [2:0] CMD_SUBS  = 3'd0;
    localparam logic [2:0] CMD_BCOND = 3'd1;
    localparam logic [2:0] CMD_ADRP  = 3'd2;
    localparam logic [2:0] CMD_ADDI  = 3'd3;
    localparam logic [2:0] CMD_MOVZ  = 3'd4;

    // shift types of the shifted register form
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;

    // condition groups, condition code bits 3:1
    localparam logic [2:0] CG_EQ = 3'd0;
    localparam logic [2:0] CG_CS = 3'd1;
    localparam logic [2:0] CG_MI = 3'd2;
    localparam logic [2:0] CG_VS = 3'd3;
    localparam logic [2:0] CG_HI = 3'd4;
    localparam logic [2:0] CG_GE = 3'd5;
    localparam logic [2:0] CG_GT = 3'd6;

    localparam logic [3:0] COND_NV = 4'hF;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] instr_word;
        logic [63:0] current_pc;
    } cmd_t;

    typedef struct packed {
        logic        branch_taken;
        logic [63:0] branch_target;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [63:0] reg_value;
        logic [3:0]  flags_nzcv;
    } res_t;

endpackage

[sv/aies_ram.sv]
module aies_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[sv/aies_alu.sv]
module aies_alu (
    input  aies_pkg::cmd_t cmd,
    input  logic [63:0]    opa,
    input  logic [63:0]    opb,
    input  logic [3:0]     nzcv,
    output aies_pkg::res_t ex
);

    always_comb
    begin
        logic [31:0] w;
        logic [4:0]  rd;
        logic        is64;
        logic [63:0] mask;
        logic [63:0] op1;
        logic [63:0] op2;
        logic [63:0] x;
        logic [5:0]  sh;
        logic [63:0] s2;
        logic [63:0] res;
        logic        neg;
        logic        ovf;
        logic [63:0] ovf_v;
        logic        n, z, c, v;
        logic        hold;
        logic [20:0] imm21;
        logic [63:0] imm;
        logic [63:0] val;

        w    = cmd.instr_word;
        rd   = w[4:0];
        is64 = w[31];
        mask = is64 ? {64{1'b1}} : {32'd0, {32{1'b1}}};

        ex               = '0;
        ex.branch_target = cmd.current_pc;
        ex.flags_nzcv    = nzcv;

        // subs shifted register datapath
        op1 = (w[9:5] == aies_pkg::SP_INDEX) ? 64'd0 : (opa & mask);
        op2 = (w[20:16] == aies_pkg::SP_INDEX) ? 64'd0 : (opb & mask);
        sh  = is64 ? w[15:10] : {1'b0, w[14:10]};
        x   = is64 ? op2 : {{32{op2[31]}}, op2[31:0]};
        case (w[23:22])
            aies_pkg::SH_LSL: s2 = (op2 << sh) & mask;
            aies_pkg::SH_LSR: s2 = op2 >> sh;
            aies_pkg::SH_ASR: s2 = 64'($signed(x) >>> sh) & mask;
            default:          s2 = op2;
        endcase
        res   = (op1 - s2) & mask;
        ovf_v = (op1 ^ s2) & (op1 ^ res);
        neg   = is64 ? res[63] : res[31];
        ovf   = is64 ? ovf_v[63] : ovf_v[31];

        // condition evaluation
        n = nzcv[3];
        z = nzcv[2];
        c = nzcv[1];
        v = nzcv[0];
        case (w[3:1])
            aies_pkg::CG_EQ: hold = z;
            aies_pkg::CG_CS: hold = c;
            aies_pkg::CG_MI: hold = n;
            aies_pkg::CG_VS: hold = v;
            aies_pkg::CG_HI: hold = c && !z;
            aies_pkg::CG_GE: hold = (n == v);
            aies_pkg::CG_GT: hold = !z && (n == v);
            default:         hold = 1'b1;
        endcase
        if (w[0] && (w[3:0] != aies_pkg::COND_NV))
        begin
            hold = !hold;
        end

        imm21 = {w[23:5], w[30:29]};
        imm   = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
        val   = 64'd0;

        case (cmd.command)
            aies_pkg::CMD_SUBS:
            begin
                ex.flags_nzcv = {neg, (res == 64'd0), (op1 >= s2), ovf};
                if (rd != aies_pkg::SP_INDEX)
                begin
                    ex.reg_written = 1'b1;
                    ex.reg_index   = rd;
                    ex.reg_value   = res;
                end
            end
            aies_pkg::CMD_BCOND:
            begin
                if (hold)
                begin
                    ex.branch_taken  = 1'b1;
                    ex.branch_target = cmd.current_pc + {{43{w[23]}}, w[23:5], 2'b00};
                end
            end
            aies_pkg::CMD_ADRP:
            begin
                if (rd != aies_pkg::SP_INDEX)
                begin
                    ex.reg_written = 1'b1;
                    ex.reg_index   = rd;
                    ex.reg_value   = {cmd.current_pc[63:12], 12'd0}
                                   + {{31{imm21[20]}}, imm21, 12'd0};
                end
            end
            aies_pkg::CMD_ADDI:
            begin
                // base and destination 31 are the stack pointer entry
                ex.reg_written = 1'b1;
                ex.reg_index   = rd;
                ex.reg_value   = (opa + imm) & mask;
            end
            aies_pkg::CMD_MOVZ:
            begin
                if (!(!is64 && w[22]) && (rd != aies_pkg::SP_INDEX))
                begin
                    val            = {48'd0, w[20:5]} << {w[22:21], 4'd0};
                    ex.reg_written = 1'b1;
                    ex.reg_index   = rd;
                    ex.reg_value   = val & mask;
                end
            end
            default:
            begin
                ex.reg_written = 1'b0;
            end
        endcase
    end

endmodule

[sv/aarch64_integer_execute_subset.sv]
// executes one aarch64 instruction per transaction (subs shifted register, b.cond, adrp,
// add immediate, movz) against 31 general registers, a stack pointer and the nzcv flags,
// and returns one result transaction per instruction; a new transaction can be taken every
// cycle while the result side is not stalled; the accepting edge loads the execute stage
// register and launches the synchronous register file read, and execute and write-back
// then load the result register, which offers the result; the general registers
// and the stack pointer share one 32-entry register file memory (entry 31 is the stack
// pointer) with two read ports, the last write-back is forwarded to the following
// instruction, and per-entry valid bits make every entry read as zero after reset, so no
// clearing pass is needed; backpressure on the result side holds the execute stage
module aarch64_integer_execute_subset (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  aies_pkg::cmd_t cmd_data,
    output logic           res_valid,
    input  logic           res_ready,
    output aies_pkg::res_t res_data
);

    localparam int AW = aies_pkg::REG_ADDR_W;

    // execute stage
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    aies_pkg::cmd_t        s1_cmd_reg;
    logic                  s1_adv;
    logic                  cmd_fire;

    // result register
    logic                  res_valid_reg;
    logic                  res_valid_next;
    aies_pkg::res_t        res_data_reg;

    // architectural flags
    logic [3:0]            flags_reg;

    // register file bookkeeping
    logic [aies_pkg::REG_DEPTH-1:0] vld_reg;
    logic                  wb_valid_reg;
    logic [AW-1:0]         wb_addr_reg;
    logic [63:0]           wb_data_reg;

    logic [63:0]           rdata_a;
    logic [63:0]           rdata_b;
    logic [AW-1:0]         ra;
    logic [AW-1:0]         rb;
    logic [63:0]           opa;
    logic [63:0]           opb;
    logic                  rf_we;
    aies_pkg::res_t        ex;

    assign s1_adv    = s1_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !s1_valid_reg || s1_adv;
    assign cmd_fire  = cmd_valid && cmd_ready;

    assign s1_valid_next  = cmd_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign res_valid_next = s1_adv ? 1'b1 : ((res_valid_reg && res_ready) ? 1'b0 : res_valid_reg);

    // read addresses come straight from the incoming instruction word
    aies_ram #(
        .WIDTH (aies_pkg::REG_W),
        .DEPTH (aies_pkg::REG_DEPTH)
    ) u_rf (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (ex.reg_index),
        .wdata   (ex.reg_value),
        .re      (cmd_fire),
        .raddr_a (cmd_data.instr_word[9:5]),
        .raddr_b (cmd_data.instr_word[20:16]),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign ra = s1_cmd_reg.instr_word[9:5];
    assign rb = s1_cmd_reg.instr_word[20:16];

    // forward the previous write-back, which the memory read missed; unwritten entries are zero
    always_comb
    begin
        if (wb_valid_reg && (wb_addr_reg == ra))
        begin
            opa = wb_data_reg;
        end
        else
        begin
            opa = vld_reg[ra] ? rdata_a : 64'd0;
        end
        if (wb_valid_reg && (wb_addr_reg == rb))
        begin
            opb = wb_data_reg;
        end
        else
        begin
            opb = vld_reg[rb] ? rdata_b : 64'd0;
        end
    end

    aies_alu u_alu (
        .cmd  (s1_cmd_reg),
        .opa  (opa),
        .opb  (opb),
        .nzcv (flags_reg),
        .ex   (ex)
    );

    assign rf_we = s1_adv && ex.reg_written;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            flags_reg     <= 4'd0;
            vld_reg       <= '0;
            wb_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (s1_adv)
            begin
                flags_reg <= ex.flags_nzcv;
            end
            if (rf_we)
            begin
                vld_reg[ex.reg_index] <= 1'b1;
                wb_valid_reg          <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_cmd_reg <= cmd_data;
        end
        if (s1_adv)
        begin
            res_data_reg <= ex;
        end
        if (rf_we)
        begin
            wb_addr_reg <= ex.reg_index;
            wb_data_reg <= ex.reg_value;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

[sv/aies_checker.sv]
module aies_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input aies_pkg::cmd_t cmd_data,
    input logic           res_valid,
    input logic           res_ready,
    input aies_pkg::res_t res_data
);

    // a stalled command holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_data))
        else $error("command changed while stalled");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // every accepted command is followed by a pending result once it has passed the execute stage and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> ##1 res_valid)
        else $error("no result after accepted command");

    // a taken branch never writes a register
    a_branch_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.branch_taken |-> !res_data.reg_written)
        else $error("branch result with register write");

    // no write reports zero index and value
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.reg_written |->
            (res_data.reg_index == 5'd0) && (res_data.reg_value == 64'd0))
        else $error("non-zero destination without write");

endmodule

bind aarch64_integer_execute_subset aies_checker u_aies_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no transaction on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT  = 3000;
    // length of the long result-side stall
    localparam int HOLD_OFF_CYCLES = 400;
    // cycles allowed after the last expected result (pipeline is two deep)
    localparam int DRAIN_CYCLES    = 10;
    localparam logic [63:0] MASK32 = 64'h0000_0000_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    aies_pkg::cmd_t cmd_data;
    logic res_valid;
    logic res_ready;
    aies_pkg::res_t res_data;

    // architectural state as the testbench expects it
    logic [63:0] gpr_model [31];
    logic [63:0] sp_model;
    logic [3:0]  nzcv_model;

    // results predicted at command acceptance, oldest first
    aies_pkg::res_t exp_results [$];

    int  fail_count   = 0;
    int  report_count = 0;
    int  quiet_cycles = 0;
    int  hold_left    = 0;
    bit  idle_on      = 1'b1;

    aarch64_integer_execute_subset u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // instruction encoders, only the fields the block decodes matter
    // ------------------------------------------------------------------

    function automatic logic [31:0] enc_subs(input logic sf, input logic [1:0] st,
                                             input logic [4:0] rm, input logic [5:0] imm6,
                                             input logic [4:0] rn, input logic [4:0] rd);
        return {sf, 2'b11, 5'b01011, st, 1'b0, rm, imm6, rn, rd};
    endfunction

    function automatic logic [31:0] enc_bcond(input logic [18:0] imm19, input logic [3:0] cond);
        return {8'b01010100, imm19, 1'b0, cond};
    endfunction

    function automatic logic [31:0] enc_adrp(input logic [1:0] immlo, input logic [18:0] immhi,
                                             input logic [4:0] rd);
        return {1'b1, immlo, 5'b10000, immhi, rd};
    endfunction

    function automatic logic [31:0] enc_addi(input logic sf, input logic sh,
                                             input logic [11:0] imm12, input logic [4:0] rn,
                                             input logic [4:0] rd);
        return {sf, 2'b00, 6'b100010, sh, imm12, rn, rd};
    endfunction

    function automatic logic [31:0] enc_movz(input logic sf, input logic [1:0] hw,
                                             input logic [15:0] imm16, input logic [4:0] rd);
        return {sf, 8'b10100101, hw, imm16, rd};
    endfunction

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic logic [63:0] sign_ext21(input logic [20:0] v);
        return {{43{v[20]}}, v};
    endfunction

    // register 31 reads as zero in the shifted register form
    function automatic logic [63:0] reg_or_zero(input logic [4:0] r);
        return (r == aies_pkg::SP_INDEX) ? 64'd0 : gpr_model[r];
    endfunction

    // executes one instruction on the model state and returns its result
    function automatic aies_pkg::res_t execute_model(input aies_pkg::cmd_t c);
        logic [31:0] w;
        logic [4:0]  rd;
        logic [4:0]  rn;
        logic        is64;
        logic [63:0] mask;
        logic [63:0] sign;
        logic [63:0] op1;
        logic [63:0] op2;
        logic [63:0] s2;
        logic [63:0] x;
        logic [63:0] val;
        logic [63:0] imm;
        logic [5:0]  sh;
        logic [1:0]  hw;
        logic [3:0]  cond;
        logic        holds;
        aies_pkg::res_t r;

        w    = c.instr_word;
        rd   = w[4:0];
        rn   = w[9:5];
        is64 = w[31];
        r    = '0;
        r.branch_target = c.current_pc;

        case (c.command)
            aies_pkg::CMD_SUBS:
            begin
                mask = is64 ? 64'hFFFF_FFFF_FFFF_FFFF : MASK32;
                sign = is64 ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
                op1  = reg_or_zero(rn) & mask;
                op2  = reg_or_zero(w[20:16]) & mask;
                // 32-bit form only honours the low five bits of the amount
                sh   = is64 ? w[15:10] : {1'b0, w[14:10]};
                case (w[23:22])
                    aies_pkg::SH_LSL: s2 = (op2 << sh) & mask;
                    aies_pkg::SH_LSR: s2 = op2 >> sh;
                    aies_pkg::SH_ASR:
                    begin
                        x  = is64 ? op2 : {{32{op2[31]}}, op2[31:0]};
                        s2 = $signed(x) >>> sh;
                        s2 = s2 & mask;
                    end
                    // reserved shift type passes the operand through
                    default: s2 = op2;
                endcase
                val = (op1 - s2) & mask;
                if (rd != aies_pkg::SP_INDEX)
                begin
                    gpr_model[rd] = val;
                    r.reg_written = 1'b1;
                    r.reg_index   = rd;
                    r.reg_value   = val;
                end
                // flags update even when the destination is the zero register
                nzcv_model = {(val & sign) != 64'd0, val == 64'd0, op1 >= s2,
                              ((op1 ^ s2) & (op1 ^ val) & sign) != 64'd0};
            end
            aies_pkg::CMD_BCOND:
            begin
                cond = w[3:0];
                case (cond[3:1])
                    aies_pkg::CG_EQ: holds = nzcv_model[2];
                    aies_pkg::CG_CS: holds = nzcv_model[1];
                    aies_pkg::CG_MI: holds = nzcv_model[3];
                    aies_pkg::CG_VS: holds = nzcv_model[0];
                    aies_pkg::CG_HI: holds = nzcv_model[1] && !nzcv_model[2];
                    aies_pkg::CG_GE: holds = nzcv_model[3] == nzcv_model[0];
                    aies_pkg::CG_GT: holds = !nzcv_model[2]
                                             && (nzcv_model[3] == nzcv_model[0]);
                    default:         holds = 1'b1;
                endcase
                // odd codes invert, except nv which always holds
                if (cond[0] && cond != aies_pkg::COND_NV)
                    holds = !holds;
                if (holds)
                begin
                    r.branch_taken  = 1'b1;
                    r.branch_target = c.current_pc + sign_ext21({w[23:5], 2'b00});
                end
            end
            aies_pkg::CMD_ADRP:
            begin
                val = (c.current_pc & ~64'hFFF) + (sign_ext21({w[23:5], w[30:29]}) << 12);
                if (rd != aies_pkg::SP_INDEX)
                begin
                    gpr_model[rd] = val;
                    r.reg_written = 1'b1;
                    r.reg_index   = rd;
                    r.reg_value   = val;
                end
            end
            aies_pkg::CMD_ADDI:
            begin
                // only bit 22 of the shift field counts
                imm = {52'd0, w[21:10]};
                if (w[22])
                    imm = imm << 12;
                op1 = (rn == aies_pkg::SP_INDEX) ? sp_model : gpr_model[rn];
                val = op1 + imm;
                if (!is64)
                    val = val & MASK32;
                if (rd == aies_pkg::SP_INDEX)
                    sp_model = val;
                else
                    gpr_model[rd] = val;
                r.reg_written = 1'b1;
                r.reg_index   = rd;
                r.reg_value   = val;
            end
            aies_pkg::CMD_MOVZ:
            begin
                hw = w[22:21];
                // 32-bit form with the upper half-word positions does nothing
                if (!(!is64 && hw[1]) && rd != aies_pkg::SP_INDEX)
                begin
                    val = {48'd0, w[20:5]} << {hw, 4'b0000};
                    if (!is64)
                        val = val & MASK32;
                    gpr_model[rd] = val;
                    r.reg_written = 1'b1;
                    r.reg_index   = rd;
                    r.reg_value   = val;
                end
            end
            // unused command codes leave everything alone
            default: ;
        endcase

        r.flags_nzcv = nzcv_model;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // command side driver
    // ------------------------------------------------------------------

    // presents one command from a falling edge, holds it until accepted and
    // records the expected result; returns at the falling edge that follows
    task automatic issue_instr(input logic [2:0] cmd, input logic [31:0] word,
                               input logic [63:0] pc);
        aies_pkg::cmd_t c;

        c.command    = cmd;
        c.instr_word = word;
        c.current_pc = pc;
        while (idle_on && $urandom_range(0, 99) < 16)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        exp_results.push_back(execute_model(c));
        @(negedge clk);
    endtask

    function automatic logic [63:0] random_pc();
        logic [63:0] pc;

        pc = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       pc = 64'd0;
            1:       pc = '1;
            2:       pc = pc & 64'h0000_0000_00FF_FFFF;
            default: ;
        endcase
        return pc;
    endfunction

    // mostly well-formed instructions with random fields, some raw noise
    task automatic issue_random();
        logic [31:0] word;
        logic [2:0]  cmd;
        int          pick;

        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            // raw word under any command code, the unused ones included
            cmd  = 3'($urandom_range(0, 7));
            word = $urandom;
        end
        else if (pick < 40)
        begin
            cmd  = aies_pkg::CMD_SUBS;
            word = enc_subs(1'($urandom), 2'($urandom), 5'($urandom), 6'($urandom),
                            5'($urandom), 5'($urandom));
        end
        else if (pick < 58)
        begin
            cmd  = aies_pkg::CMD_BCOND;
            word = enc_bcond(19'($urandom), 4'($urandom));
        end
        else if (pick < 68)
        begin
            cmd  = aies_pkg::CMD_ADRP;
            word = enc_adrp(2'($urandom), 19'($urandom), 5'($urandom));
        end
        else if (pick < 84)
        begin
            cmd  = aies_pkg::CMD_ADDI;
            word = enc_addi(1'($urandom), 1'($urandom), 12'($urandom), 5'($urandom),
                            5'($urandom));
            // stray bit 23 in the shift field
            if ($urandom_range(0, 7) == 0)
                word[23] = 1'b1;
        end
        else
        begin
            cmd  = aies_pkg::CMD_MOVZ;
            word = enc_movz(1'($urandom), 2'($urandom), 16'($urandom), 5'($urandom));
        end
        issue_instr(cmd, word, random_pc());
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls plus the long hold-off
    // ------------------------------------------------------------------

    initial
    begin
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 99) < 16)
                res_ready <= 1'b0;
            else
                res_ready <= 1'b1;
        end
    end

    // each result transaction against the oldest prediction
    always @(posedge clk)
    begin : result_check
        aies_pkg::res_t e;
        if (rst_n && res_valid && res_ready)
        begin
            if (exp_results.size() == 0)
            begin
                fail_count++;
                report_count++;
                if (report_count <= 10)
                    $display("%0t: result with nothing expected: taken=%0b target=%h wr=%0b idx=%0d val=%h nzcv=%b",
                             $realtime, res_data.branch_taken, res_data.branch_target,
                             res_data.reg_written, res_data.reg_index, res_data.reg_value,
                             res_data.flags_nzcv);
            end
            else
            begin
                e = exp_results.pop_front();
                if (res_data.branch_taken  !== e.branch_taken  ||
                    res_data.branch_target !== e.branch_target ||
                    res_data.reg_written   !== e.reg_written   ||
                    res_data.reg_index     !== e.reg_index     ||
                    res_data.reg_value     !== e.reg_value     ||
                    res_data.flags_nzcv    !== e.flags_nzcv)
                begin
                    fail_count++;
                    report_count++;
                    if (report_count <= 10)
                    begin
                        $display("%0t: mismatch, expected taken=%0b target=%h wr=%0b idx=%0d val=%h nzcv=%b",
                                 $realtime, e.branch_taken, e.branch_target, e.reg_written,
                                 e.reg_index, e.reg_value, e.flags_nzcv);
                        $display("%0t:           actual   taken=%0b target=%h wr=%0b idx=%0d val=%h nzcv=%b",
                                 $realtime, res_data.branch_taken, res_data.branch_target,
                                 res_data.reg_written, res_data.reg_index, res_data.reg_value,
                                 res_data.flags_nzcv);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding", exp_results.size());
                $display("** aarch64_integer_execute_subset: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes and corners of every instruction class but b.cond, and the unused command codes
    task automatic test_directed_cases();
        logic [31:0] w;

        issue_instr(aies_pkg::CMD_MOVZ, enc_movz(1'b1, 2'd3, 16'hFFFF, 5'd1), random_pc());
        issue_instr(aies_pkg::CMD_MOVZ, enc_movz(1'b0, 2'd1, 16'h8001, 5'd2), random_pc());
        // 32-bit form with hw two: no operation
        issue_instr(aies_pkg::CMD_MOVZ, enc_movz(1'b0, 2'd2, 16'h1234, 5'd3), random_pc());
        issue_instr(aies_pkg::CMD_MOVZ,
                    enc_movz(1'b1, 2'd0, 16'h0001, aies_pkg::SP_INDEX), random_pc());
        issue_instr(aies_pkg::CMD_SUBS,
                    enc_subs(1'b1, aies_pkg::SH_LSL, 5'd2, 6'd0, 5'd1, 5'd4), random_pc());
        issue_instr(aies_pkg::CMD_SUBS,
                    enc_subs(1'b1, aies_pkg::SH_LSR, 5'd2, 6'd63, 5'd1, 5'd5), random_pc());
        issue_instr(aies_pkg::CMD_SUBS,
                    enc_subs(1'b1, aies_pkg::SH_ASR, 5'd1, 6'd17, 5'd2, 5'd6), random_pc());
        // 32-bit asr of a negative word from the zero register
        issue_instr(aies_pkg::CMD_SUBS,
                    enc_subs(1'b0, aies_pkg::SH_ASR, 5'd2, 6'd31, aies_pkg::SP_INDEX, 5'd7),
                    random_pc());
        // reserved shift type
        issue_instr(aies_pkg::CMD_SUBS, enc_subs(1'b1, 2'd3, 5'd1, 6'd5, 5'd2, 5'd8),
                    random_pc());
        // 32-bit form, amount 63 truncates to 31
        issue_instr(aies_pkg::CMD_SUBS,
                    enc_subs(1'b0, aies_pkg::SH_LSL, 5'd2, 6'd63, 5'd1, 5'd9), random_pc());
        // compare into the zero register still sets flags
        issue_instr(aies_pkg::CMD_SUBS,
                    enc_subs(1'b1, aies_pkg::SH_LSL, 5'd1, 6'd0, 5'd1, aies_pkg::SP_INDEX),
                    random_pc());
        issue_instr(aies_pkg::CMD_ADDI,
                    enc_addi(1'b1, 1'b1, 12'hFFF, aies_pkg::SP_INDEX, aies_pkg::SP_INDEX),
                    random_pc());
        issue_instr(aies_pkg::CMD_ADDI,
                    enc_addi(1'b1, 1'b0, 12'hFFF, aies_pkg::SP_INDEX, 5'd10), random_pc());
        issue_instr(aies_pkg::CMD_ADDI,
                    enc_addi(1'b0, 1'b0, 12'h001, 5'd1, aies_pkg::SP_INDEX), random_pc());
        // shift field of two: bit 23 alone does not shift
        w = enc_addi(1'b1, 1'b0, 12'hFFF, 5'd1, 5'd11);
        w[23] = 1'b1;
        issue_instr(aies_pkg::CMD_ADDI, w, random_pc());
        issue_instr(aies_pkg::CMD_ADRP, enc_adrp(2'b11, 19'h7FFFF, 5'd12),
                    64'hFFFF_FFFF_FFFF_FFFF);
        issue_instr(aies_pkg::CMD_ADRP, enc_adrp(2'b00, 19'h40000, 5'd13), 64'd0);
        issue_instr(aies_pkg::CMD_ADRP, enc_adrp(2'b01, 19'h3FFFF, aies_pkg::SP_INDEX),
                    random_pc());
        issue_instr(3'd5, $urandom, random_pc());
        issue_instr(3'd6, 32'hFFFF_FFFF, random_pc());
        issue_instr(3'd7, 32'h0000_0000, random_pc());
    endtask

    // one branch per condition group, both senses, al and nv
    task automatic test_branch_conditions();
        logic [3:0] conds [9];

        conds = '{4'h0, 4'h3, 4'h4, 4'h7, 4'h8, 4'hB, 4'hD, 4'hE, aies_pkg::COND_NV};
        foreach (conds[i])
            issue_instr(aies_pkg::CMD_BCOND,
                        enc_bcond((i % 2) ? 19'h40000 : 19'h3FFFF, conds[i]), random_pc());
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            issue_random();
    endtask

    // back-to-back traffic with neither side stalling
    task automatic test_no_idling(input int count);
        idle_on = 1'b0;
        repeat (count)
            issue_random();
        idle_on = 1'b1;
    endtask

    // results held off while commands keep coming, so the input stalls
    task automatic test_backpressure(input int count);
        hold_left = HOLD_OFF_CYCLES;
        repeat (count)
            issue_random();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_data  = '0;
        foreach (gpr_model[i])
            gpr_model[i] = 64'd0;
        sp_model   = 64'd0;
        nzcv_model = 4'd0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_branch_conditions();
        test_random_mix(900);
        test_no_idling(300);
        test_backpressure(150);
        test_random_mix(470);

        cmd_valid <= 1'b0;
        while (exp_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && exp_results.size() == 0)
            $display("** aarch64_integer_execute_subset: PASSED **");
        else
            $display("** aarch64_integer_execute_subset: FAILED **");
        $finish;
    end

endmodule

[files.f]
sv/aies_pkg.sv
sv/aies_ram.sv
sv/aies_alu.sv
sv/aarch64_integer_execute_subset.sv
sv/aies_checker.sv
verif/tb_top.sv
